@@ design/pqads_pkg.sv @@
package pqads_pkg;

   localparam int SUB_W   = 3;
   localparam int CODE_W  = 8;
   localparam int VALUE_W = 32;
   localparam int ID_W    = 31;
   localparam int DIST_W  = 35;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_SCORE = 1'b1
   } op_type;

   // classified item as it travels from front to back
   typedef struct packed {
      logic                is_score;
      logic                entry_ok;
      logic                last;
      logic [SUB_W-1:0]    sub_index;
      logic [CODE_W-1:0]   code_index;
      logic [VALUE_W-1:0]  table_value;
      logic [ID_W-1:0]     vector_id;
   } cmd_type;

endpackage

@@ design/pqads_channels.sv @@
interface pqads_req_if;
   import pqads_pkg::*;

   logic                valid;
   logic                ready;
   logic                operation;
   logic [SUB_W-1:0]    sub_index;
   logic [CODE_W-1:0]   code_index;
   logic [VALUE_W-1:0]  table_value;
   logic [ID_W-1:0]     vector_id;
   logic                last_sub;

   modport source (
      output valid, operation, sub_index, code_index, table_value, vector_id, last_sub,
      input  ready
   );

   modport sink (
      input  valid, operation, sub_index, code_index, table_value, vector_id, last_sub,
      output ready
   );
endinterface

interface pqads_rsp_if;
   import pqads_pkg::*;

   logic                valid;
   logic                ready;
   logic [ID_W-1:0]     vector_id_res;
   logic [DIST_W-1:0]   distance;

   modport source (
      output valid, vector_id_res, distance,
      input  ready
   );

   modport sink (
      input  valid, vector_id_res, distance,
      output ready
   );
endinterface

@@ design/pqads_front.sv @@
module pqads_front #(
   parameter int NUM_SUBQ      = 8,
   parameter int CODEBOOK_SIZE = 256
) (
   pqads_req_if.sink             req_if,
   output logic                  push_valid,
   output pqads_pkg::cmd_type    push_cmd,
   input  logic                  push_ready
);
   import pqads_pkg::*;

   logic sub_ok;
   logic code_ok;

   // out-of-range rows or codes neither write nor add
   assign sub_ok  = (32'(req_if.sub_index) < 32'(NUM_SUBQ));
   assign code_ok = (32'(req_if.code_index) < 32'(CODEBOOK_SIZE));

   always_comb begin
      push_cmd.is_score    = (op_type'(req_if.operation) == OP_SCORE);
      push_cmd.entry_ok    = sub_ok && code_ok;
      push_cmd.last        = req_if.last_sub;
      push_cmd.sub_index   = req_if.sub_index;
      push_cmd.code_index  = req_if.code_index;
      push_cmd.table_value = req_if.table_value;
      push_cmd.vector_id   = req_if.vector_id;
   end

   assign push_valid   = req_if.valid;
   assign req_if.ready = push_ready;

endmodule

@@ design/pqads_queue.sv @@
module pqads_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  pqads_pkg::cmd_type    push_cmd,
   output logic                  push_ready,
   output logic                  pop_valid,
   output pqads_pkg::cmd_type    pop_cmd,
   input  logic                  pop_ready
);
   import pqads_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ design/pqads_back.sv @@
module pqads_back #(
   parameter int NUM_SUBQ      = 8,
   parameter int CODEBOOK_SIZE = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   input  pqads_pkg::cmd_type    pop_cmd,
   output logic                  pop_ready,
   pqads_rsp_if.source           rsp_if
);
   import pqads_pkg::*;

   localparam int DEPTH  = NUM_SUBQ * CODEBOOK_SIZE;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [VALUE_W-1:0]  table_mem [DEPTH];

   logic [31:0]         slot_wide;
   logic [ADDR_W-1:0]   slot;
   logic                advance;
   logic                take;

   logic                b_valid_ff;
   cmd_type             b_cmd_ff;
   logic [VALUE_W-1:0]  rd_data_ff;

   logic [DIST_W-1:0]   sum_ff, sum_in;
   logic [DIST_W:0]     sum_wide;
   logic [DIST_W-1:0]   sum_sat;
   logic [VALUE_W-1:0]  addend;
   logic                emit;

   logic                out_valid_ff, out_valid_in;
   logic [ID_W-1:0]     out_id_ff;
   logic [DIST_W-1:0]   out_dist_ff;

   // whole back pipeline moves only when the output register is free or being taken
   assign advance   = !out_valid_ff || rsp_if.ready;
   assign pop_ready = advance;
   assign take      = pop_valid && advance;

   assign slot_wide = 32'(pop_cmd.sub_index) * 32'(CODEBOOK_SIZE) + 32'(pop_cmd.code_index);
   assign slot      = slot_wide[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (take && !pop_cmd.is_score && pop_cmd.entry_ok) begin
         table_mem[slot] <= pop_cmd.table_value;
      end
      if (take) begin
         rd_data_ff <= table_mem[slot];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         b_cmd_ff <= pop_cmd;
      end
   end

   // accumulate with saturation at the top of the sum range
   always_comb begin
      addend   = b_cmd_ff.entry_ok ? rd_data_ff : '0;
      sum_wide = {1'b0, sum_ff} + (DIST_W + 1)'(addend);
      sum_sat  = sum_wide[DIST_W] ? {DIST_W{1'b1}} : sum_wide[DIST_W-1:0];
      emit     = advance && b_valid_ff && b_cmd_ff.is_score && b_cmd_ff.last;
      sum_in   = sum_ff;
      if (advance && b_valid_ff && b_cmd_ff.is_score) begin
         sum_in = b_cmd_ff.last ? '0 : sum_sat;
      end
      out_valid_in = advance ? emit : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_id_ff   <= b_cmd_ff.vector_id;
         out_dist_ff <= sum_sat;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.vector_id_res = out_id_ff;
   assign rsp_if.distance      = out_dist_ff;

endmodule

@@ design/pq_adc_distance_scan.sv @@
// channel   dir   handshake          payload
// req_if    in    valid / ready      operation, sub_index, code_index, table_value,
//                                    vector_id, last_sub
// rsp_if    out   valid / ready      vector_id_res, distance
//
// Sustains one item per cycle while no result waits on rsp_if. The edge that takes
// the last score item of a vector writes the front-to-back queue; the item then goes
// through the registered table read port, and the add goes into the output register
// that drives rsp_if.
// Reset clears the queue, the pipeline, the running sum and the output register;
// the distance table holds no reset value and must be loaded before it is scored.
// A result left waiting freezes the back end; the two-entry queue then fills and
// req_if.ready drops.
module pq_adc_distance_scan #(
   parameter int NUM_SUBQ      = 8,
   parameter int CODEBOOK_SIZE = 256
) (
   input  logic         clock,
   input  logic         reset,
   pqads_req_if.sink    req_if,
   pqads_rsp_if.source  rsp_if
);
   import pqads_pkg::*;

   logic     push_valid;
   logic     push_ready;
   cmd_type  push_cmd;
   logic     pop_valid;
   logic     pop_ready;
   cmd_type  pop_cmd;

   pqads_front #(
      .NUM_SUBQ      (NUM_SUBQ),
      .CODEBOOK_SIZE (CODEBOOK_SIZE)
   ) u_front (
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   pqads_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   pqads_back #(
      .NUM_SUBQ      (NUM_SUBQ),
      .CODEBOOK_SIZE (CODEBOOK_SIZE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd),
      .pop_ready (pop_ready),
      .rsp_if    (rsp_if)
   );

endmodule

@@ tb/sv/tb_pq_adc_distance_scan.sv @@
module tb_pq_adc_distance_scan;
   import pqads_pkg::*;

   localparam int NUM_ENTRIES = 1 << (SUB_W + CODE_W);
   localparam int ITEMS_TOTAL = 1650;

   typedef struct packed {
      op_type              op;
      logic [SUB_W-1:0]    sub;
      logic [CODE_W-1:0]   code;
      logic [VALUE_W-1:0]  value;
      logic [ID_W-1:0]     vid;
      logic                last;
   } scan_item_type;

   typedef struct packed {
      logic [ID_W-1:0]     vid;
      logic [DIST_W-1:0]   total;
   } vector_score_type;

   class distance_scoreboard;
      logic [VALUE_W-1:0]  dist_lut [NUM_ENTRIES];
      logic [DIST_W-1:0]   partial_sum;
      vector_score_type    expected_scores [$];
      int                  failures;

      function new();
         partial_sum = '0;
         failures    = 0;
      endfunction

      function void note_item(scan_item_type it);
         logic [DIST_W:0] widened;
         int              slot;
         slot = {it.sub, it.code};
         if (it.op == OP_LOAD) begin
            dist_lut[slot] = it.value;
            return;
         end
         // saturate at all ones when the add carries out of the sum width
         widened     = partial_sum + dist_lut[slot];
         partial_sum = widened[DIST_W] ? '1 : widened[DIST_W-1:0];
         if (it.last) begin
            expected_scores.push_back('{it.vid, partial_sum});
            partial_sum = '0;
         end
      endfunction

      function void check_result(logic [ID_W-1:0] vid, logic [DIST_W-1:0] distance);
         vector_score_type exp_score;
         if (expected_scores.size() == 0) begin
            $error("unexpected result: vector_id_res %0h distance %0h", vid, distance);
            failures++;
            return;
         end
         exp_score = expected_scores.pop_front();
         if (vid !== exp_score.vid) begin
            $error("vector_id_res: expected %0h, got %0h", exp_score.vid, vid);
            failures++;
         end
         if (distance !== exp_score.total) begin
            $error("distance: expected %0h, got %0h", exp_score.total, distance);
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   pqads_req_if req_ch ();
   pqads_rsp_if rsp_ch ();

   pq_adc_distance_scan DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   distance_scoreboard sb = new();

   bit loaded [NUM_ENTRIES];
   bit calm      = 1'b0;
   bit tx_gappy  = 1'b1;
   int items_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_item(input op_type op, input logic [SUB_W-1:0] sub,
                            input logic [CODE_W-1:0] code, input logic [VALUE_W-1:0] value,
                            input logic [ID_W-1:0] vid, input logic last);
      scan_item_type it;
      if (!calm && tx_gappy && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      it = '{op, sub, code, value, vid, last};
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= op;
      req_ch.sub_index   <= sub;
      req_ch.code_index  <= code;
      req_ch.table_value <= value;
      req_ch.vector_id   <= vid;
      req_ch.last_sub    <= last;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_item(it);
      if (op == OP_LOAD) loaded[{sub, code}] = 1'b1;
      items_sent++;
   endtask

   // load the entry first if it was never written, then score it
   task automatic score_code(input logic [SUB_W-1:0] sub, input logic [CODE_W-1:0] code,
                             input logic [ID_W-1:0] vid, input logic last);
      if (!loaded[{sub, code}])
         send_item(OP_LOAD, sub, code, $urandom, ID_W'($urandom), 1'($urandom_range(0, 1)));
      send_item(OP_SCORE, sub, code, $urandom, vid, last);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_result(rsp_ch.vector_id_res, rsp_ch.distance);
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (!calm && $urandom_range(0, 2) != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
      end
   end

   initial begin
      int                 len;
      int                 roll;
      logic [SUB_W-1:0]   sub;
      logic [CODE_W-1:0]  code;

      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.operation   <= OP_LOAD;
      req_ch.sub_index   <= '0;
      req_ch.code_index  <= '0;
      req_ch.table_value <= '0;
      req_ch.vector_id   <= '0;
      req_ch.last_sub    <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // corners: zero and full entries, load carrying last, load inside a vector
      send_item(OP_LOAD, 3'd0, 8'd0, 32'h0000_0000, 31'h0, 1'b1);
      send_item(OP_LOAD, 3'd7, 8'd255, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b0);
      send_item(OP_LOAD, 3'd3, 8'd128, 32'hAAAA_AAAA, 31'h2AAA_AAAA, 1'b0);
      send_item(OP_LOAD, 3'd4, 8'd127, 32'h5555_5555, 31'h5555_5555, 1'b1);
      send_item(OP_SCORE, 3'd0, 8'd0, 32'hFFFF_FFFF, 31'h0, 1'b1);
      send_item(OP_SCORE, 3'd7, 8'd255, 32'h0, 31'h7FFF_FFFF, 1'b1);
      send_item(OP_SCORE, 3'd3, 8'd128, 32'h0, 31'h2AAA_AAAA, 1'b0);
      send_item(OP_LOAD, 3'd1, 8'd1, 32'h0001_8000, 31'h1, 1'b1);
      send_item(OP_SCORE, 3'd4, 8'd127, 32'h0, 31'h5555_5555, 1'b1);
      send_item(OP_SCORE, 3'd1, 8'd1, 32'h0, 31'h1, 1'b1);
      // nine full entries run the sum past its top
      for (int i = 0; i < 9; i++)
         send_item(OP_SCORE, 3'd7, 8'd255, 32'h0, 31'h0123_4567, 1'(i == 8));

      while (items_sent < ITEMS_TOTAL) begin
         calm     = items_sent > ITEMS_TOTAL * 85 / 100;
         tx_gappy = $urandom_range(0, 3) != 0;
         roll     = $urandom_range(0, 99);
         if (roll < 15) begin
            repeat ($urandom_range(1, 6))
               send_item(OP_LOAD, SUB_W'($urandom_range(0, 7)), CODE_W'($urandom_range(0, 255)),
                         $urandom, ID_W'($urandom), 1'($urandom_range(0, 1)));
         end else if (roll < 25) begin
            // long vector over near-full entries, nearly always ends saturated
            len = $urandom_range(9, 20);
            for (int i = 0; i < len; i++) begin
               sub  = SUB_W'($urandom_range(0, 7));
               code = CODE_W'($urandom_range(0, 255));
               send_item(OP_LOAD, sub, code, $urandom_range(32'hFFFF_FFFF, 32'hE000_0000),
                         ID_W'($urandom), 1'($urandom_range(0, 1)));
               score_code(sub, code, ID_W'($urandom), 1'(i == len - 1));
            end
         end else begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
               sub  = (roll < 85) ? SUB_W'(i) : SUB_W'($urandom_range(0, 7));
               code = CODE_W'($urandom_range(0, 255));
               if ($urandom_range(0, 19) == 0)
                  send_item(OP_LOAD, SUB_W'($urandom_range(0, 7)),
                            CODE_W'($urandom_range(0, 255)), $urandom, ID_W'($urandom),
                            1'($urandom_range(0, 1)));
               score_code(sub, code, ID_W'($urandom), 1'(i == len - 1));
            end
         end
      end
      req_ch.valid <= 1'b0;

      while (sb.expected_scores.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.failures == 0)
         $display("** pq_adc_distance_scan: PASSED **");
      else
         $display("** pq_adc_distance_scan: FAILED **");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("** pq_adc_distance_scan: FAILED **");
      $finish;
   end

endmodule

@@ filelist.f @@
design/pqads_pkg.sv
design/pqads_channels.sv
design/pqads_front.sv
design/pqads_queue.sv
design/pqads_back.sv
design/pq_adc_distance_scan.sv
tb/sv/tb_pq_adc_distance_scan.sv
